// ----- src/fied_pkg.sv -----
package fied_pkg;

  localparam int DEPTH_DEF = 16;

  localparam int VAL_W = 32;
  localparam int POS_W = 4;
  localparam int OCC_W = 5;

  typedef enum logic [1:0] {
    OP_PUSH = 2'd0,
    OP_POP  = 2'd1,
    OP_EDIT = 2'd2,
    OP_DEL  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_FULL   = 2'd2,
    ST_BADPOS = 2'd3
  } status_t;

  typedef struct packed {
    func_t                    func;
    logic signed [VAL_W-1:0]  item_value;
    logic        [POS_W-1:0]  position;
  } in_req_t;

  typedef struct packed {
    logic signed [VAL_W-1:0]  read_value;
    status_t                  status;
    logic        [OCC_W-1:0]  occupancy;
  } out_rsp_t;

  // which operation actually takes effect
  typedef struct packed {
    logic push;
    logic pop;
    logic edit;
    logic del;
  } op_go_t;

  // per-cell control
  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctl_t;

endpackage

// ----- src/fied_cell.sv -----
module fied_cell
  import fied_pkg::*;
(
  input  logic                    clk,
  input  cell_ctl_t               ctl,
  input  logic signed [VAL_W-1:0] load_value,
  input  logic signed [VAL_W-1:0] right_value,
  output logic signed [VAL_W-1:0] value
);

  logic signed [VAL_W-1:0] value_r;
  logic signed [VAL_W-1:0] value_nxt;

  always_comb begin
    value_nxt = value_r;
    if (ctl.load) begin
      value_nxt = load_value;
    end else if (ctl.shift) begin
      value_nxt = right_value;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  assign value = value_r;

endmodule

// ----- src/fied_ctrl.sv -----
module fied_ctrl
  import fied_pkg::*;
(
  input  func_t                           func,
  input  logic [POS_W-1:0]                position,
  input  logic [$clog2(DEPTH_DEF+1)-1:0]  count,
  output status_t                         status,
  output op_go_t                          go
);

  localparam int CW   = $clog2(DEPTH_DEF + 1);
  localparam int CMPW = (CW > POS_W) ? CW : POS_W;

  logic [CMPW-1:0] pos_x;
  logic [CMPW-1:0] cnt_x;
  logic            empty;
  logic            full;
  logic            bad_pos;

  assign pos_x   = CMPW'(position);
  assign cnt_x   = CMPW'(count);
  assign empty   = (count == '0);
  assign full    = (count == CW'(DEPTH_DEF));
  assign bad_pos = (pos_x >= cnt_x);

  // empty check wins over position check
  always_comb begin
    status = ST_OK;
    go     = '0;
    unique case (func)
      OP_PUSH: begin
        if (full) status = ST_FULL;
        else      go.push = 1'b1;
      end
      OP_POP: begin
        if (empty) status = ST_EMPTY;
        else       go.pop = 1'b1;
      end
      OP_EDIT: begin
        if (empty)        status = ST_EMPTY;
        else if (bad_pos) status = ST_BADPOS;
        else              go.edit = 1'b1;
      end
      OP_DEL: begin
        if (empty)        status = ST_EMPTY;
        else if (bad_pos) status = ST_BADPOS;
        else              go.del = 1'b1;
      end
      default: status = ST_OK;
    endcase
  end

endmodule

// ----- src/fifo_with_indexed_edit_delete.sv -----
// Ordered queue with push, pop, indexed edit and indexed delete.
// The result is registered and is valid in the cycle after the request is accepted.
// Throughput: one request per cycle while in_stall is low; every cell updates in
//   parallel, so even a delete takes no longer than any other request.
// Reset (rst_n low, synchronous): occupancy and result valid clear; cell
//   contents are left as they are and are only read below the occupancy.
module fifo_with_indexed_edit_delete
  import fied_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_req_t  in_req,
  output logic     out_valid,
  input  logic     out_stall,
  output out_rsp_t out_rsp
);

  // depth is tied to the 4-bit position and 5-bit occupancy fields
  localparam int DEPTH = DEPTH_DEF;
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int CMPW  = (CW > POS_W) ? CW : POS_W;

  // occupancy
  logic [CW-1:0] count_r;
  logic [CW-1:0] count_nxt;

  // result register
  logic     out_valid_r;
  logic     out_valid_nxt;
  out_rsp_t out_rsp_r;
  out_rsp_t out_rsp_nxt;

  logic    accept;
  status_t status;
  op_go_t  go;

  logic signed [VAL_W-1:0] cell_value [DEPTH];
  cell_ctl_t               cell_ctl   [DEPTH];
  logic        [CMPW-1:0]  pos_x;

  // A new request is taken whenever the result slot is free or draining.
  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;
  assign pos_x    = CMPW'(in_req.position);

  fied_ctrl u_ctrl (
    .func     (in_req.func),
    .position (in_req.position),
    .count    (count_r),
    .status   (status),
    .go       (go)
  );

  // Cell row: cell 0 is the front. Pop shifts every cell left by one,
  // delete shifts the cells at and above the position. Push loads the
  // cell at the rear, edit loads the cell at the position. Cells beyond
  // the occupancy may pick up stale data; they are never read.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [VAL_W-1:0] right_value;

    if (i == DEPTH - 1) begin : g_last
      assign right_value = cell_value[i];
    end else begin : g_mid
      assign right_value = cell_value[i+1];
    end

    assign cell_ctl[i].load  = accept && ((go.push && (count_r == CW'(i))) ||
                                          (go.edit && (pos_x == CMPW'(i))));
    assign cell_ctl[i].shift = accept && (go.pop || (go.del && (CMPW'(i) >= pos_x)));

    fied_cell u_cell (
      .clk         (clk),
      .ctl         (cell_ctl[i]),
      .load_value  (in_req.item_value),
      .right_value (right_value),
      .value       (cell_value[i])
    );
  end

  always_comb begin
    count_nxt = count_r;
    if (accept) begin
      if (go.push)               count_nxt = count_r + CW'(1);
      else if (go.pop || go.del) count_nxt = count_r - CW'(1);
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    out_rsp_nxt   = out_rsp_r;
    if (accept) begin
      out_valid_nxt          = 1'b1;
      out_rsp_nxt.read_value = go.pop ? cell_value[0] : '0;
      out_rsp_nxt.status     = status;
      out_rsp_nxt.occupancy  = OCC_W'(count_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    out_rsp_r <= out_rsp_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 1ps

// Testbench for the ordered queue with push, pop, indexed edit and indexed delete.
// A shadow queue predicts every response when its request is accepted. Responses
// are checked in order, field by field. Both handshake sides idle at random, and
// one long receiver hold-off fills the block until it stalls its input.
module tb;
  import fied_pkg::*;

  localparam int HOLD_CYCLES = 200;   // long receiver hold-off
  localparam int QUIET_LIMIT = 4000;  // watchdog: cycles with no transfer at all
  localparam int FLUSH_CYCLES = 8;    // settle time after the last response

  logic     clk;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  in_req_t  in_req = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  out_rsp_t out_rsp;

  fifo_with_indexed_edit_delete dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_req   (in_req),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_rsp  (out_rsp)
  );

  // Shadow of the queue contents, front at index 0.
  logic signed [VAL_W-1:0] shadow_q[$];
  // Responses predicted but not yet seen, oldest first.
  out_rsp_t pending_rsp[$];

  int  req_count = 0;
  int  rsp_count = 0;
  int  err_count = 0;
  int  in_stall_seen = 0;
  int  status_seen[4] = '{0, 0, 0, 0};
  bit  tx_idle_en = 1'b1;  // sender may leave gaps
  bit  rx_idle_en = 1'b1;  // receiver may stall
  bit  rx_hold_req = 1'b0; // ask the receiver for one long hold-off

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Gap length: mostly none, often short, now and then long.
  function automatic int idle_len();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Applies one request to the shadow queue and returns the response it yields.
  function automatic out_rsp_t apply_queue_op(in_req_t r);
    out_rsp_t rsp;
    rsp = '0;
    rsp.status = ST_OK;
    if (r.func == OP_PUSH) begin
      if (shadow_q.size() >= DEPTH_DEF) rsp.status = ST_FULL;
      else shadow_q.push_back(r.item_value);
    end else if (shadow_q.size() == 0) begin
      // empty wins over a bad position
      rsp.status = ST_EMPTY;
    end else if (r.func == OP_POP) begin
      rsp.read_value = shadow_q.pop_front();
    end else if (int'(r.position) >= shadow_q.size()) begin
      rsp.status = ST_BADPOS;
    end else if (r.func == OP_EDIT) begin
      shadow_q[r.position] = r.item_value;
    end else begin
      shadow_q.delete(int'(r.position));
    end
    rsp.occupancy = OCC_W'(shadow_q.size());
    return rsp;
  endfunction

  // Offers one request, waits for the handshake and records its prediction.
  // Called right after a rising edge; returns right after the accepting edge.
  task automatic send_req(in_req_t r);
    int gap;
    gap = tx_idle_en ? idle_len() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= r;
    do begin
      @(posedge clk);
      if (in_stall) in_stall_seen++;
    end while (in_stall);
    pending_rsp.push_back(apply_queue_op(r));
    req_count++;
  endtask

  function automatic logic signed [VAL_W-1:0] rand_value();
    case ($urandom_range(0, 15))
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      2:       return '0;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // Random request; push_pct sets the drift toward full or empty.
  // Positions mostly land inside the current occupancy.
  function automatic in_req_t rand_req(int push_pct);
    in_req_t r;
    int pick;
    pick = $urandom_range(0, 99);
    r.item_value = rand_value();
    if (pick < push_pct) r.func = OP_PUSH;
    else if (pick < push_pct + (100 - push_pct) / 2) r.func = OP_POP;
    else if ($urandom_range(0, 1) == 0) r.func = OP_EDIT;
    else r.func = OP_DEL;
    if (shadow_q.size() > 0 && $urandom_range(0, 4) != 0)
      r.position = POS_W'($urandom_range(0, shadow_q.size() - 1));
    else
      r.position = POS_W'($urandom_range(0, 15));
    return r;
  endfunction

  function automatic in_req_t mk_req(func_t f, logic signed [VAL_W-1:0] v,
                                     logic [POS_W-1:0] p);
    in_req_t r;
    r.func       = f;
    r.item_value = v;
    r.position   = p;
    return r;
  endfunction

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin : rx_side
    int left;
    left = 0;
    forever begin
      @(posedge clk);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
        left = 0;
      end else if (left > 0) begin
        left--;
      end else begin
        left = rx_idle_en ? idle_len() : 0;
        out_stall <= (left != 0);
      end
    end
  end

  // Response checker: in order against the oldest prediction.
  always @(posedge clk) begin : rsp_check
    out_rsp_t want;
    if (rst_n && out_valid && !out_stall) begin
      rsp_count++;
      status_seen[int'(out_rsp.status)]++;
      if (pending_rsp.size() == 0) begin
        $display("%0t: unexpected response %p", $time, out_rsp);
        err_count++;
      end else begin
        want = pending_rsp.pop_front();
        if (out_rsp.read_value !== want.read_value) begin
          $display("%0t: read_value exp %0d got %0d", $time,
                   want.read_value, out_rsp.read_value);
          err_count++;
        end
        if (out_rsp.status !== want.status) begin
          $display("%0t: status exp %s got %s", $time,
                   want.status.name(), out_rsp.status.name());
          err_count++;
        end
        if (out_rsp.occupancy !== want.occupancy) begin
          $display("%0t: occupancy exp %0d got %0d", $time,
                   want.occupancy, out_rsp.occupancy);
          err_count++;
        end
      end
    end
  end

  // Watchdog: ends the run if neither side moves for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
    $display("Simulation FAILED");
    $finish;
  end

  // Pop, edit and delete on an empty queue; a bad position on delete must
  // still report empty since that check comes first.
  task automatic test_empty_queue();
    send_req(mk_req(OP_POP, 32'sd5, 4'd0));
    send_req(mk_req(OP_EDIT, 32'sd7, 4'd0));
    send_req(mk_req(OP_DEL, '0, 4'd15));
  endtask

  // Fill to DEPTH, starting with extreme values, then push once more: refused as full.
  task automatic test_fill_to_full();
    logic signed [VAL_W-1:0] v;
    for (int i = 0; i < DEPTH_DEF; i++) begin
      case (i)
        0:       v = 32'sh7FFF_FFFF;
        1:       v = 32'sh8000_0000;
        2:       v = '0;
        3:       v = '1;
        default: v = $urandom;
      endcase
      send_req(mk_req(OP_PUSH, v, POS_W'(i)));
    end
    send_req(mk_req(OP_PUSH, 32'sh1234_5678, 4'd0));
  endtask

  // Edit front and rear, delete rear then front, then out-of-range positions.
  task automatic test_edit_delete_edges();
    send_req(mk_req(OP_EDIT, 32'sh8000_0000, 4'd0));
    send_req(mk_req(OP_EDIT, 32'sh7FFF_FFFF, 4'd15));
    send_req(mk_req(OP_DEL, '0, 4'd15));
    send_req(mk_req(OP_DEL, '0, 4'd0));
    send_req(mk_req(OP_EDIT, 32'sd99, 4'd14));
    send_req(mk_req(OP_DEL, '0, 4'd15));
  endtask

  // Alternating fill-heavy and drain-heavy bursts, so the queue swings
  // between full and empty; idling switches on and off per burst.
  task automatic test_random_traffic(int bursts);
    for (int b = 0; b < bursts; b++) begin
      tx_idle_en = ($urandom_range(0, 3) != 0);
      rx_idle_en = ($urandom_range(0, 3) != 0);
      for (int i = 0; i < 100; i++)
        send_req(rand_req((b % 2 == 0) ? 65 : 30));
    end
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
  endtask

  // Receiver holds off for a long stretch while the sender keeps offering,
  // so the block backs up and stalls its input.
  task automatic test_output_backpressure();
    tx_idle_en  = 1'b0;
    rx_hold_req = 1'b1;
    for (int i = 0; i < 60; i++)
      send_req(rand_req(50));
    tx_idle_en = 1'b1;
  endtask

  initial begin : main
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_queue();
    test_fill_to_full();
    test_edit_delete_edges();
    test_random_traffic(4);
    test_output_backpressure();
    test_random_traffic(4);

    in_valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (FLUSH_CYCLES) @(posedge clk);

    $display("Requests %0d, responses %0d, input stalls seen %0d", req_count,
             rsp_count, in_stall_seen);
    $display("Status counts: ok %0d, empty %0d, full %0d, bad position %0d",
             status_seen[ST_OK], status_seen[ST_EMPTY], status_seen[ST_FULL],
             status_seen[ST_BADPOS]);
    if (err_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
